/* src/rcec_pkg.sv */
// ----------------------------------------------------------------------------
// rcec_pkg
// Shared types and constants for the reference-counted entry cache.
// ----------------------------------------------------------------------------
`default_nettype none

package rcec_pkg;

   localparam int SLOTS   = 64;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int DEV_W   = 8;
   localparam int OBJ_W   = 16;
   localparam int KEY_W   = DEV_W + OBJ_W;
   localparam int CNT_W   = 16;
   localparam int KIND_W  = 2;
   localparam int STS_W   = 2;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_GET  = 2'd0,
      KIND_DUP  = 2'd1,
      KIND_DROP = 2'd2,
      KIND_RSVD = 2'd3
   } kind_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_UNUSED   = 2'd2,
      STS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FETCH,
      S_UPDATE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;      // capture request fields
      logic             rd_en;     // read slot tables
      logic             use_slot;  // read address from request slot field
      logic [IDX_W-1:0] rd_addr;   // scan address
      logic             chk;       // compare read data of previous cycle
      logic             commit;    // update tables and load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit_now;   // read data matches the requested key
      logic out_free;  // result register can take a new transaction
   } sts_type;

endpackage

`default_nettype wire

/* src/rcec_ctrl.sv */
// ----------------------------------------------------------------------------
// rcec_ctrl
// Sequencer: accepts requests, drives the table scan and the commit step.
// ----------------------------------------------------------------------------
`default_nettype none

module rcec_ctrl
   import rcec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_stall,
   input  wire sts_type           sts,
   output cmd_type                cmd
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (req_valid) begin
               case (kind_type'(req_kind))
                  KIND_GET:            state_in = S_SCAN;
                  KIND_DUP, KIND_DROP: state_in = S_FETCH;
                  default:             state_in = S_IDLE;  // reserved kind: drop it
               endcase
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (sts.hit_now) begin
               state_in = S_UPDATE;
            end else if (scan_ff == LAST_SLOT) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN:  state_in = S_UPDATE;
         S_FETCH:  state_in = S_UPDATE;
         S_UPDATE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cmd.rd_addr = scan_ff;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.chk   = (scan_ff != '0);
         end
         S_DRAIN: begin
            cmd.chk = 1'b1;
         end
         S_FETCH: begin
            cmd.rd_en    = 1'b1;
            cmd.use_slot = 1'b1;
         end
         S_UPDATE: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/rcec_datapath.sv */
// ----------------------------------------------------------------------------
// rcec_datapath
// Slot tables, scan compare, count update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcec_datapath
   import rcec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [DEV_W-1:0]  req_device,
   input  wire logic [OBJ_W-1:0]  req_object_number,
   input  wire logic [IDX_W-1:0]  req_slot,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [IDX_W-1:0]       rsp_slot_index,
   output logic                   rsp_hit,
   output logic                   rsp_freed,
   output logic [CNT_W-1:0]       rsp_count_after,
   output logic [STS_W-1:0]       rsp_status
);

   // slot tables
   logic [KEY_W-1:0] key_mem [SLOTS];
   logic [CNT_W-1:0] cnt_mem [SLOTS];
   logic [SLOTS-1:0] vld_ff;

   // captured request
   kind_type         kind_ff;
   logic [KEY_W-1:0] key_ff;
   logic [IDX_W-1:0] slot_ff;

   // registered read port
   logic [KEY_W-1:0] rd_key_ff;
   logic [CNT_W-1:0] rd_cnt_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] rd_addr;

   // scan results
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [CNT_W-1:0] hit_cnt_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_hit_ff;
   logic             rsp_freed_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   status_type       rsp_sts_ff;

   logic [CNT_W-1:0] rd_cnt_eff;
   logic             in_use;
   logic             hit_now;
   logic             free_now;
   logic             out_free;

   logic             wr_cnt_en;
   logic             wr_key_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CNT_W-1:0] wr_cnt;
   logic [IDX_W-1:0] res_idx;
   logic             res_hit;
   logic             res_freed;
   logic [CNT_W-1:0] res_cnt;
   status_type       res_sts;

   assign rd_addr    = cmd.use_slot ? slot_ff : cmd.rd_addr;
   assign rd_cnt_eff = rd_vld_ff ? rd_cnt_ff : '0;
   assign in_use     = (rd_cnt_eff != '0);
   assign hit_now    = cmd.chk && !hit_ff && in_use && (rd_key_ff == key_ff);
   assign free_now   = cmd.chk && !free_ff && !in_use;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign sts = '{hit_now: hit_now, out_free: out_free};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(req_kind);
         key_ff  <= {req_device, req_object_number};
         slot_ff <= req_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_cnt_ff <= cnt_mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (wr_cnt_en) begin
         cnt_mem[wr_addr] <= wr_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_cnt_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (hit_now) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_cnt_ff <= rd_cnt_eff;
         end
         if (free_now) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // commit: result and table update
   always_comb begin
      wr_cnt_en = 1'b0;
      wr_key_en = 1'b0;
      wr_addr   = slot_ff;
      wr_cnt    = '0;
      res_idx   = slot_ff;
      res_hit   = 1'b0;
      res_freed = 1'b0;
      res_cnt   = '0;
      res_sts   = STS_OK;
      case (kind_ff)
         KIND_GET: begin
            if (hit_ff) begin
               res_idx = hit_idx_ff;
               wr_addr = hit_idx_ff;
               res_hit = 1'b1;
               if (hit_cnt_ff == COUNT_MAX) begin
                  res_cnt = COUNT_MAX;
                  res_sts = STS_OVERFLOW;
               end else begin
                  wr_cnt    = hit_cnt_ff + 1'b1;
                  wr_cnt_en = cmd.commit;
                  res_cnt   = wr_cnt;
               end
            end else if (free_ff) begin
               res_idx   = free_idx_ff;
               wr_addr   = free_idx_ff;
               wr_cnt    = CNT_W'(1);
               wr_cnt_en = cmd.commit;
               wr_key_en = cmd.commit;
               res_cnt   = wr_cnt;
            end else begin
               res_idx = '0;
               res_sts = STS_FULL;
            end
         end
         KIND_DUP: begin
            if (rd_cnt_eff == '0) begin
               res_sts = STS_UNUSED;
            end else if (rd_cnt_eff == COUNT_MAX) begin
               res_cnt = COUNT_MAX;
               res_sts = STS_OVERFLOW;
            end else begin
               wr_cnt    = rd_cnt_eff + 1'b1;
               wr_cnt_en = cmd.commit;
               res_cnt   = wr_cnt;
            end
         end
         KIND_DROP: begin
            if (rd_cnt_eff == '0) begin
               res_sts = STS_UNUSED;
            end else begin
               wr_cnt    = rd_cnt_eff - 1'b1;
               wr_cnt_en = cmd.commit;
               res_cnt   = wr_cnt;
               res_freed = (wr_cnt == '0);
            end
         end
         default: begin
            res_sts = STS_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_idx_ff   <= res_idx;
         rsp_hit_ff   <= res_hit;
         rsp_freed_ff <= res_freed;
         rsp_cnt_ff   <= res_cnt;
         rsp_sts_ff   <= res_sts;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_idx_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_freed       = rsp_freed_ff;
   assign rsp_count_after = rsp_cnt_ff;
   assign rsp_status      = rsp_sts_ff;

endmodule

`default_nettype wire

/* src/refcounted_entry_cache.sv */
// ----------------------------------------------------------------------------
// refcounted_entry_cache
// Table of 64 reference-counted slots keyed by device and object number.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A get reads the slot tables through
// their single read port, one slot per cycle; a get that misses runs an
// accept step, 64 scan reads, one compare step and one commit step, while
// a get that hits commits as soon as the matching slot has been compared.
// Duplicate and drop read only the one slot named by the request.
// The result sits in an output register, so the next request is accepted
// while a result still waits to be taken; a commit waits only if that
// register is still full. Reserved kind 3 is accepted and gives no result.
`default_nettype none

module refcounted_entry_cache
   import rcec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [DEV_W-1:0]  req_device,
   input  wire logic [OBJ_W-1:0]  req_object_number,
   input  wire logic [IDX_W-1:0]  req_slot,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [IDX_W-1:0]       rsp_slot_index,
   output logic                   rsp_hit,
   output logic                   rsp_freed,
   output logic [CNT_W-1:0]       rsp_count_after,
   output logic [STS_W-1:0]       rsp_status
);

   cmd_type cmd;
   sts_type sts;

   rcec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcec_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_device        (req_device),
      .req_object_number (req_object_number),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_hit           (rsp_hit),
      .rsp_freed         (rsp_freed),
      .rsp_count_after   (rsp_count_after),
      .rsp_status        (rsp_status)
   );

   // a real request, once accepted, holds off the next request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_kind != KIND_RSVD)) |=> req_stall)
      else $error("input not held off after request transaction");

   a_freed_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_freed) |->
         (rsp_count_after == '0 && rsp_status == STS_OK && !rsp_hit))
      else $error("freed result with nonzero count or bad status");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_FULL) |->
         (rsp_count_after == '0 && rsp_slot_index == '0 && !rsp_hit))
      else $error("table-full result carries slot data");

   a_ok_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_OK && !rsp_freed) |->
         (rsp_count_after != '0))
      else $error("ok result with zero count but not freed");

endmodule

`default_nettype wire
